/* rtl/core/sdpb_pkg.sv */
// shared types and constants for the scan-line dma program builder
// used by sdpb_cfg_regs and scanline_dma_program_builder_core; no dependencies

package sdpb_pkg;

    localparam logic [12:0] SEGMENT_BYTES  = 13'd4096;
    localparam logic [10:0] MAX_LINES      = 11'd1024;
    localparam logic [11:0] MAX_LINE_BYTES = 12'd4095;
    localparam logic [6:0]  RESULT_LIMIT   = 7'd64;

    localparam logic [23:0] START_OFFSET_RST   = 24'd0;
    localparam logic [11:0] BYTES_PER_LINE_RST = 12'd1280;
    localparam logic [23:0] LINE_PADDING_RST   = 24'd0;
    localparam logic [10:0] LINE_COUNT_RST     = 11'd288;

    typedef enum logic [1:0] {
        REG_START_OFFSET   = 2'd0,
        REG_BYTES_PER_LINE = 2'd1,
        REG_LINE_PADDING   = 2'd2,
        REG_LINE_COUNT     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [23:0] start_offset;
        logic [11:0] bytes_per_line;
        logic [23:0] line_padding;
        logic [10:0] line_count;
    } cfg_t;

    typedef struct packed {
        logic        is_sync;
        logic [31:0] write_address;
        logic [11:0] byte_count;
        logic        start_of_line;
        logic        end_of_line;
        logic        frame_done;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

/* rtl/core/sdpb_cfg_regs.sv */
// configuration register file for the scan-line dma program builder
// depends on sdpb_pkg for the register indexes, reset values and cfg_t

module sdpb_cfg_regs
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  sdpb_pkg::cfg_index_t    wr_index,
    input  logic [23:0]             wr_data,
    output sdpb_pkg::cfg_t          cfg
);

    sdpb_pkg::cfg_t cfg_reg;
    sdpb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                sdpb_pkg::REG_START_OFFSET:   cfg_next.start_offset   = wr_data;
                sdpb_pkg::REG_BYTES_PER_LINE: cfg_next.bytes_per_line = wr_data[11:0];
                sdpb_pkg::REG_LINE_PADDING:   cfg_next.line_padding   = wr_data;
                sdpb_pkg::REG_LINE_COUNT:     cfg_next.line_count     = wr_data[10:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_offset   <= sdpb_pkg::START_OFFSET_RST;
            cfg_reg.bytes_per_line <= sdpb_pkg::BYTES_PER_LINE_RST;
            cfg_reg.line_padding   <= sdpb_pkg::LINE_PADDING_RST;
            cfg_reg.line_count     <= sdpb_pkg::LINE_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/scanline_dma_program_builder_core.sv */
// scan-line dma program builder: cuts scatter-gather segments into line write pieces
// depends on sdpb_pkg and sdpb_cfg_regs
// a segment is accepted in idle; the run state then takes one skip run or write piece per
// step and a closing step hands on any pending result; output stalls hold pieces and the
// closing step but not skip runs; the single min/compare unit allows one item per step
// a sync or write piece passes the pending register and then the output register to appear
// async active-low reset clears control state; no program runs until a start of list

module scanline_dma_program_builder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // segment input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seg_address,
    input  logic [12:0] seg_length,
    input  logic        start_of_list,
    // instruction output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_sync,
    output logic [31:0] write_address,
    output logic [11:0] byte_count,
    output logic        start_of_line,
    output logic        end_of_line,
    output logic        frame_done,
    output logic        last
);

    sdpb_pkg::cfg_t cfg;

    assign cfg_ready = 1'b1;

    sdpb_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (sdpb_pkg::cfg_index_t'(cfg_index)),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // control state
    sdpb_pkg::state_t state_reg, state_next;
    logic        complete_reg, complete_next;
    logic [10:0] lines_done_reg, lines_done_next;
    logic [23:0] skip_reg, skip_next;
    logic [11:0] progress_reg, progress_next;
    logic [12:0] pos_reg, pos_next;
    logic [6:0]  count_reg, count_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        out_valid_reg, out_valid_next;

    // payload state
    logic [31:0] base_reg, base_next;
    logic [12:0] len_reg, len_next;
    logic [11:0] lat_bpl_reg, lat_bpl_next;
    logic [23:0] lat_pad_reg, lat_pad_next;
    logic [10:0] lat_lines_reg, lat_lines_next;
    sdpb_pkg::result_t pend_reg, pend_next;
    sdpb_pkg::result_t out_reg, out_next;
    logic        out_last_reg, out_last_next;

    logic        in_xfer;
    logic        out_free;
    logic [12:0] avail;
    logic [11:0] need;
    logic        run_on;
    logic        is_skip;
    logic [23:0] op_a;
    logic [23:0] op_b;
    logic        a_le_b;
    logic [23:0] take;
    logic [10:0] lines_inc;
    logic [11:0] bpl_sat;
    logic [10:0] lines_sat;
    sdpb_pkg::result_t piece;

    assign in_stall = (state_reg != sdpb_pkg::ST_IDLE);
    assign in_xfer  = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;

    assign bpl_sat   = (cfg.bytes_per_line > sdpb_pkg::MAX_LINE_BYTES) ?
                       sdpb_pkg::MAX_LINE_BYTES : cfg.bytes_per_line;
    assign lines_sat = (cfg.line_count > sdpb_pkg::MAX_LINES) ?
                       sdpb_pkg::MAX_LINES : cfg.line_count;

    // shared min unit: serves both the skip run and the line piece
    assign avail   = len_reg - pos_reg;
    assign need    = lat_bpl_reg - progress_reg;
    assign is_skip = (progress_reg == 12'd0) && (skip_reg != 24'd0);
    assign op_a    = is_skip ? skip_reg : {12'd0, need};
    assign op_b    = {11'd0, avail};
    assign a_le_b  = (op_a <= op_b);
    assign take    = a_le_b ? op_a : op_b;

    assign run_on    = ~complete_reg && (pos_reg < len_reg) &&
                       (count_reg < sdpb_pkg::RESULT_LIMIT);
    assign lines_inc = lines_done_reg + 11'd1;

    always_comb
    begin
        piece.is_sync       = 1'b0;
        piece.write_address = base_reg + {19'd0, pos_reg};
        piece.byte_count    = take[11:0];
        piece.start_of_line = (progress_reg == 12'd0);
        piece.end_of_line   = a_le_b;
        piece.frame_done    = a_le_b && (lines_inc >= lat_lines_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        complete_next   = complete_reg;
        lines_done_next = lines_done_reg;
        skip_next       = skip_reg;
        progress_next   = progress_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        lat_bpl_next    = lat_bpl_reg;
        lat_pad_next    = lat_pad_reg;
        lat_lines_next  = lat_lines_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg & out_stall;

        unique case (state_reg)
            sdpb_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    base_next  = seg_address;
                    len_next   = (seg_length > sdpb_pkg::SEGMENT_BYTES) ?
                                 sdpb_pkg::SEGMENT_BYTES : seg_length;
                    pos_next   = 13'd0;
                    state_next = sdpb_pkg::ST_RUN;
                    if (start_of_list)
                    begin
                        lat_bpl_next    = bpl_sat;
                        lat_pad_next    = cfg.line_padding;
                        lat_lines_next  = lines_sat;
                        lines_done_next = 11'd0;
                        progress_next   = 12'd0;
                        skip_next       = cfg.start_offset;
                        complete_next   = (bpl_sat == 12'd0) || (lines_sat == 11'd0);
                        pend_next       = '0;
                        pend_next.is_sync = 1'b1;
                        pend_valid_next = 1'b1;
                        count_next      = 7'd1;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        count_next      = 7'd0;
                    end
                end
            end
            sdpb_pkg::ST_RUN:
            begin
                if (run_on && is_skip)
                begin
                    // skip run: consumes bytes, yields nothing
                    skip_next = skip_reg - take;
                    pos_next  = pos_reg + take[12:0];
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_last_next  = ~run_on;
                        out_valid_next = 1'b1;
                    end
                    if (run_on)
                    begin
                        pend_next       = piece;
                        pend_valid_next = 1'b1;
                        count_next      = count_reg + 7'd1;
                        pos_next        = pos_reg + take[12:0];
                        if (a_le_b)
                        begin
                            progress_next   = 12'd0;
                            lines_done_next = lines_inc;
                            skip_next       = lat_pad_reg;
                            if (lines_inc >= lat_lines_reg)
                            begin
                                complete_next = 1'b1;
                            end
                        end
                        else
                        begin
                            progress_next = progress_reg + take[11:0];
                        end
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = sdpb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sdpb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdpb_pkg::ST_IDLE;
            complete_reg   <= 1'b1;
            lines_done_reg <= 11'd0;
            skip_reg       <= 24'd0;
            progress_reg   <= 12'd0;
            pos_reg        <= 13'd0;
            count_reg      <= 7'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            complete_reg   <= complete_next;
            lines_done_reg <= lines_done_next;
            skip_reg       <= skip_next;
            progress_reg   <= progress_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        len_reg       <= len_next;
        lat_bpl_reg   <= lat_bpl_next;
        lat_pad_reg   <= lat_pad_next;
        lat_lines_reg <= lat_lines_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign is_sync       = out_reg.is_sync;
    assign write_address = out_reg.write_address;
    assign byte_count    = out_reg.byte_count;
    assign start_of_line = out_reg.start_of_line;
    assign end_of_line   = out_reg.end_of_line;
    assign frame_done    = out_reg.frame_done;
    assign last          = out_last_reg;

`ifndef SYNTHESIS
    // nothing may be held back once the block is idle
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdpb_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sdpb_pkg::RESULT_LIMIT)
        else $error("result count beyond limit");

    a_pos_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdpb_pkg::ST_RUN) |-> (pos_reg <= len_reg))
        else $error("segment position past its length");

    a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.is_sync) |-> (out_reg.byte_count != 12'd0))
        else $error("empty write piece");

    a_progress_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdpb_pkg::ST_RUN && !complete_reg) |-> (progress_reg < lat_bpl_reg))
        else $error("line progress past line length");
`endif

endmodule

/* dv/scanline_dma_program_builder_core_tb.sv */
// testbench for scanline_dma_program_builder_core: sends scatter-gather segments and
// checks every write and sync instruction against a line layout predictor kept here
// depends on sdpb_pkg and the core rtl
`timescale 1ns / 1ps

module scanline_dma_program_builder_core_tb;

    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 400;

    typedef struct packed {
        logic        is_sync;
        logic [31:0] write_address;
        logic [11:0] byte_count;
        logic        start_of_line;
        logic        end_of_line;
        logic        frame_done;
        logic        last;
    } program_instr_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] seg_address = '0;
    logic [12:0] seg_length = '0;
    logic        start_of_list = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        is_sync;
    logic [31:0] write_address;
    logic [11:0] byte_count;
    logic        start_of_line;
    logic        end_of_line;
    logic        frame_done;
    logic        last;

    // predictor state: register file, values latched at start of list, layout progress
    sdpb_pkg::cfg_t reg_file = '{sdpb_pkg::START_OFFSET_RST, sdpb_pkg::BYTES_PER_LINE_RST,
                                 sdpb_pkg::LINE_PADDING_RST, sdpb_pkg::LINE_COUNT_RST};
    logic [11:0] line_bytes_latched = '0;
    logic [23:0] line_gap_latched = '0;
    logic [10:0] frame_lines_latched = '0;
    logic [10:0] lines_done = '0;
    logic [23:0] skip_remaining = '0;
    logic [11:0] line_fill = '0;
    logic        frame_complete = 1'b1;

    program_instr_t expected_instrs[$];
    int unsigned    segments_sent = 0;
    int unsigned    failures = 0;
    int unsigned    cycle_count = 0;
    int unsigned    tx_idle_pct = 15;
    int unsigned    rx_idle_pct = 64;
    int unsigned    hold_requests = 0;
    int unsigned    holds_served = 0;
    int unsigned    hold_left = 0;

    scanline_dma_program_builder_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .seg_address   (seg_address),
        .seg_length    (seg_length),
        .start_of_list (start_of_list),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_sync       (is_sync),
        .write_address (write_address),
        .byte_count    (byte_count),
        .start_of_line (start_of_line),
        .end_of_line   (end_of_line),
        .frame_done    (frame_done),
        .last          (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("scanline_dma_program_builder_core regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic string format_instr(input program_instr_t ins);
        return $sformatf("sync=%0b addr=%h bytes=%0d sol=%0b eol=%0b done=%0b last=%0b",
                         ins.is_sync, ins.write_address, ins.byte_count, ins.start_of_line,
                         ins.end_of_line, ins.frame_done, ins.last);
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin
        program_instr_t got;
        program_instr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{is_sync, write_address, byte_count, start_of_line, end_of_line,
                    frame_done, last};
            if (expected_instrs.size() == 0)
            begin
                note_failure({"unexpected instruction: ", format_instr(got)});
            end
            else
            begin
                want = expected_instrs.pop_front();
                if (got !== want)
                    note_failure({"instruction mismatch\n  expected ", format_instr(want),
                                  "\n  actual   ", format_instr(got)});
            end
        end
    end

    // lays one accepted segment over the frame and queues the instructions it yields
    function automatic void layout_segment(input logic [31:0] base, input logic [12:0] len_in,
                                           input logic sol);
        program_instr_t step_instrs[$];
        program_instr_t ins;
        int unsigned    len;
        int unsigned    pos;
        int unsigned    avail;
        int unsigned    need;
        int unsigned    take;
        len = 32'(len_in);
        pos = 0;
        segments_sent++;
        if (len > 32'(sdpb_pkg::SEGMENT_BYTES))
            len = 32'(sdpb_pkg::SEGMENT_BYTES);
        if (sol)
        begin
            line_bytes_latched  = (reg_file.bytes_per_line > sdpb_pkg::MAX_LINE_BYTES) ?
                                  sdpb_pkg::MAX_LINE_BYTES : reg_file.bytes_per_line;
            line_gap_latched    = reg_file.line_padding;
            frame_lines_latched = (reg_file.line_count > sdpb_pkg::MAX_LINES) ?
                                  sdpb_pkg::MAX_LINES : reg_file.line_count;
            lines_done          = '0;
            line_fill           = '0;
            skip_remaining      = reg_file.start_offset;
            frame_complete      = (line_bytes_latched == 0) || (frame_lines_latched == 0);
            ins                 = '0;
            ins.is_sync         = 1'b1;
            step_instrs.push_back(ins);
        end
        while (!frame_complete && pos < len && step_instrs.size() < sdpb_pkg::RESULT_LIMIT)
        begin
            avail = len - pos;
            if (line_fill == 0 && skip_remaining != 0)
            begin
                take = (32'(skip_remaining) < avail) ? 32'(skip_remaining) : avail;
                skip_remaining = 24'(32'(skip_remaining) - take);
                pos += take;
            end
            else
            begin
                need              = 32'(line_bytes_latched) - 32'(line_fill);
                take              = (need < avail) ? need : avail;
                ins               = '0;
                ins.write_address = base + pos;
                ins.byte_count    = 12'(take);
                ins.start_of_line = (line_fill == 0);
                ins.end_of_line   = (take == need);
                pos += take;
                line_fill = 12'(32'(line_fill) + take);
                if (ins.end_of_line)
                begin
                    line_fill      = '0;
                    lines_done     = lines_done + 11'd1;
                    skip_remaining = line_gap_latched;
                    if (lines_done >= frame_lines_latched)
                    begin
                        frame_complete = 1'b1;
                        ins.frame_done = 1'b1;
                    end
                end
                step_instrs.push_back(ins);
            end
        end
        if (step_instrs.size() != 0)
            step_instrs[$].last = 1'b1;
        foreach (step_instrs[i])
            expected_instrs.push_back(step_instrs[i]);
    endfunction

    // called at a rising edge; returns at the edge of the transfer with valid still high
    task automatic offer_segment(input logic [31:0] addr, input logic [12:0] len,
                                 input logic sol);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        seg_address   <= addr;
        seg_length    <= len;
        start_of_list <= sol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        layout_segment(addr, len, sol);
    endtask

    task automatic wait_for_program_drain();
        in_valid <= 1'b0;
        while (expected_instrs.size() != 0)
            @(posedge clk);
        // segments that yield nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sdpb_pkg::cfg_index_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sdpb_pkg::REG_START_OFFSET:   reg_file.start_offset   = value;
            sdpb_pkg::REG_BYTES_PER_LINE: reg_file.bytes_per_line = value[11:0];
            sdpb_pkg::REG_LINE_PADDING:   reg_file.line_padding   = value;
            sdpb_pkg::REG_LINE_COUNT:     reg_file.line_count     = value[10:0];
            default: ;
        endcase
    endtask

    // only called when idle; upper bits beyond a register's width are don't-care
    task automatic program_regs(input logic [23:0] offset, input logic [23:0] line_bytes,
                                input logic [23:0] padding, input logic [23:0] lines);
        write_reg(sdpb_pkg::REG_START_OFFSET, offset);
        write_reg(sdpb_pkg::REG_BYTES_PER_LINE, line_bytes);
        write_reg(sdpb_pkg::REG_LINE_PADDING, padding);
        write_reg(sdpb_pkg::REG_LINE_COUNT, lines);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [12:0] random_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return 13'($urandom_range(8191, 4097));
        else if (r < 60)
            return 13'($urandom_range(600, 1));
        else
            return 13'($urandom_range(4096, 1));
    endfunction

    task automatic randomize_regs();
        logic [23:0] offset;
        logic [11:0] line_bytes;
        logic [23:0] padding;
        logic [10:0] lines;
        int unsigned r;
        r = $urandom_range(99);
        offset = (r < 50) ? 24'd0 : (r < 95) ? 24'($urandom_range(2000)) : 24'($urandom);
        r = $urandom_range(99);
        line_bytes = (r < 3) ? 12'd0 : (r < 70) ? 12'($urandom_range(700, 1)) :
                     12'($urandom_range(4095, 1));
        r = $urandom_range(99);
        padding = (r < 50) ? 24'd0 : (r < 95) ? 24'($urandom_range(1500)) : 24'($urandom);
        r = $urandom_range(99);
        lines = (r < 3) ? 11'd0 : (r < 80) ? 11'($urandom_range(8, 1)) :
                11'($urandom_range(2047, 1));
        program_regs(offset, {12'($urandom), line_bytes}, padding, {13'($urandom), lines});
    endtask

    // mostly a start of list followed by plain segments; some lists are broken
    task automatic send_random_list();
        int unsigned segs;
        logic        broken;
        segs   = $urandom_range(10, 2);
        broken = ($urandom_range(99) < 10);
        for (int i = 0; i < segs; i++)
            offer_segment($urandom, random_length(),
                          broken ? ($urandom_range(3) == 0) : (i == 0));
    endtask

    task automatic test_before_first_list();
        offer_segment(32'hFFFF_FFFF, 13'h1FFF, 1'b0);
        wait_for_program_drain();
    endtask

    task automatic test_field_extremes();
        // reset layout, addresses wrapping past the top of the bus
        offer_segment(32'hFFFF_F800, 13'd4096, 1'b1);
        offer_segment(32'h0000_0000, 13'd0, 1'b0);
        offer_segment(32'h8000_0000, 13'h1FFF, 1'b0);
        offer_segment(32'h5555_5555, 13'd0, 1'b1);
        wait_for_program_drain();
        program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        offer_segment(32'hAAAA_AAAA, 13'd4096, 1'b1);
        wait_for_program_drain();
        program_regs(24'd16, 24'd4095, 24'hFFFFFF, 24'd2047);
        offer_segment(32'h1234_5678, 13'h1FFF, 1'b1);
        offer_segment(32'h8765_4320, 13'd4096, 1'b0);
        wait_for_program_drain();
        // zero line length, then zero line count
        program_regs(24'd0, 24'd0, 24'd0, 24'd5);
        offer_segment(32'h0000_1000, 13'd100, 1'b1);
        offer_segment(32'h0000_2000, 13'd100, 1'b0);
        wait_for_program_drain();
        program_regs(24'd0, 24'd16, 24'd0, 24'd0);
        offer_segment(32'h0000_3000, 13'd100, 1'b1);
        wait_for_program_drain();
        // single line frame; the rest of the list is ignored
        program_regs(24'd3, 24'd10, 24'd5, 24'd1);
        offer_segment(32'hFFFF_FFFF, 13'd100, 1'b1);
        offer_segment(32'h0000_4000, 13'd50, 1'b0);
        wait_for_program_drain();
        // lines and padding split across segment borders
        program_regs(24'd0, 24'd7, 24'd2, 24'd3);
        offer_segment(32'h0001_0000, 13'd5, 1'b1);
        offer_segment(32'h0002_0000, 13'd3, 1'b0);
        offer_segment(32'h0003_0000, 13'd20, 1'b0);
        wait_for_program_drain();
    endtask

    task automatic test_instr_overflow();
        program_regs(24'd0, 24'd1, 24'd0, 24'd1024);
        offer_segment(32'h1000_0000, 13'd4096, 1'b1);
        offer_segment(32'h2000_0000, 13'd4096, 1'b0);
        wait_for_program_drain();
        program_regs(24'd0, 24'd1, 24'd1, 24'd1024);
        offer_segment(32'h3000_0000, 13'd200, 1'b1);
        wait_for_program_drain();
    endtask

    task automatic test_register_latching();
        program_regs(24'd20, 24'd100, 24'd10, 24'd3);
        offer_segment(32'h0040_0000, 13'd150, 1'b1);
        wait_for_program_drain();
        // new values must not touch the running program
        program_regs(24'd0, 24'd50, 24'd0, 24'd1);
        offer_segment(32'h0050_0000, 13'd400, 1'b0);
        offer_segment(32'h0060_0000, 13'd300, 1'b1);
        wait_for_program_drain();
    endtask

    task automatic test_backpressure();
        program_regs(24'd0, 24'd300, 24'd20, 24'd1024);
        tx_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        offer_segment($urandom, 13'd1500, 1'b1);
        repeat (30)
            offer_segment($urandom, 13'($urandom_range(1500, 100)), 1'b0);
        wait_for_program_drain();
        tx_idle_pct = 15;
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned goal);
        int unsigned first;
        first       = segments_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        while (segments_sent - first < goal)
        begin
            wait_for_program_drain();
            randomize_regs();
            repeat ($urandom_range(3, 1))
                send_random_list();
        end
        wait_for_program_drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_first_list();
        test_field_extremes();
        test_instr_overflow();
        test_register_latching();
        test_backpressure();
        test_random_traffic(15, 64, 70);
        test_random_traffic(64, 15, 70);
        test_random_traffic(0, 0, 70);
        if (failures == 0)
            $display("scanline_dma_program_builder_core regression: pass");
        else
            $display("scanline_dma_program_builder_core regression: fail");
        $finish;
    end

endmodule
